/* sv/pwlm_pkg.sv */
// ============================================================================
// pwlm_pkg: shared types and constants of the peak window level meter
// Holds the request and result layouts, register map, reset values and the
// command and status bundles between controller and datapath.
// ============================================================================
package pwlm_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int SAMPLE_BITS  = 10;
  localparam int LEVEL_BITS   = 10;
  localparam int REG_BITS     = 10;
  localparam int LED_BITS     = 4;
  localparam int NUM_SAMPLES  = 5;

  localparam int WIN_AW = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  // sum of five samples, and sum of the middle three
  localparam int SUM_W = SAMPLE_BITS + 3;
  localparam int MID_W = SAMPLE_BITS + 2;

  // divide by three as multiply by a rounded-up reciprocal and shift;
  // exact for every value below 2**DIV3_SHIFT
  localparam int DIV3_SHIFT = MID_W + 1;
  localparam int DIV3_MUL   = ((2 ** DIV3_SHIFT) + 2) / 3;
  localparam int PROD_W     = 2 * MID_W;

  // configuration port
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CENTER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPIKE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THR1   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THR2   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THR3   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_THRF   = 3'd5;

  localparam logic [REG_BITS-1:0] RST_CENTER = 10'd512;
  localparam logic [REG_BITS-1:0] RST_SPIKE  = 10'd320;
  localparam logic [REG_BITS-1:0] RST_THR1   = 10'd12;
  localparam logic [REG_BITS-1:0] RST_THR2   = 10'd20;
  localparam logic [REG_BITS-1:0] RST_THR3   = 10'd35;
  localparam logic [REG_BITS-1:0] RST_THRF   = 10'd80;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  localparam logic [LED_BITS-1:0] PAT_NONE  = 4'b0000;
  localparam logic [LED_BITS-1:0] PAT_ONE   = 4'b0001;
  localparam logic [LED_BITS-1:0] PAT_TWO   = 4'b0011;
  localparam logic [LED_BITS-1:0] PAT_THREE = 4'b0111;
  localparam logic [LED_BITS-1:0] PAT_FULL  = 4'b1111;

  typedef struct packed {
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
    logic [SAMPLE_BITS-1:0] sample_d;
    logic [SAMPLE_BITS-1:0] sample_e;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_pushed;
    logic [LEVEL_BITS-1:0] window_peak;
    logic [LED_BITS-1:0]   led_pattern;
  } out_item_t;

  typedef struct packed {
    logic [REG_BITS-1:0] center_level;
    logic [REG_BITS-1:0] spike_limit;
    logic [REG_BITS-1:0] threshold_one;
    logic [REG_BITS-1:0] threshold_two;
    logic [REG_BITS-1:0] threshold_three;
    logic [REG_BITS-1:0] threshold_full;
  } cfg_t;

  typedef struct packed {
    logic load;      // capture request, clear scan and result state
    logic sort_en;   // register min, max and sum of the set
    logic div_en;    // register the middle average
    logic push;      // write the level into the window
    logic scan_rd;   // read one window entry and advance
    logic pat_en;    // update the bar pattern from the peak
    logic out_load;  // load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic cmd;        // command of the request in flight
    logic scan_done;  // every filled window entry has been read
  } dp_sts_t;

endpackage

/* sv/peak_window_level_meter_core.sv */
// ============================================================================
// peak_window_level_meter_core: sliding-window peak meter with LED bar graph
// Sample requests push a filtered deviation level into a window of recent
// levels; refresh requests scan the window for its peak and drive a
// four-LED thermometer pattern.
// ============================================================================
//
//  channel   direction  payload      transfer
//  in_       input      in_item_t    in_valid high, in_stall low
//  out_      output     out_item_t   out_valid high, out_stall low
//  cfg       input      6 x 10 bit   psel, penable, pwrite, pready high
//
//  A sample request passes through min/max/sum, divide by three, window write
//  and result load in turn; capture is at the accepting edge.
//  A refresh request scans every filled window entry, then updates the pattern;
//  the window memory's single read port gives one entry per cycle.
//  Reset clears the window fill count, write pointer and bar pattern; no
//  clearing pass is needed. One request is in flight at a time; a result
//  held by out_stall does not block acceptance, only the next result load.
//
module peak_window_level_meter_core import pwlm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // register file: thresholds, centre and spike limit
  pwlm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequence each request and hold the result valid
  pwlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  // arithmetic, window memory and result register
  pwlm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (ctl_cmd),
    .sts      (dp_sts),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // at most one datapath action per cycle
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl_cmd.load, ctl_cmd.sort_en, ctl_cmd.div_en, ctl_cmd.push,
              ctl_cmd.scan_rd, ctl_cmd.pat_en, ctl_cmd.out_load}))
    else $error("controller issued more than one datapath action");

  // an accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in flight");

  // a result appears only after a result load
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctl_cmd.out_load))
    else $error("result valid raised without a result load");

  // the scan never reads beyond the filled part of the window
  a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.scan_rd |-> !dp_sts.scan_done)
    else $error("window scan read beyond the fill count");
`endif

endmodule

/* sv/pwlm_regs.sv */
// ============================================================================
// pwlm_regs: configuration register file
// Six 10-bit registers behind a simple bus port, one word apart.
// ============================================================================
module pwlm_regs import pwlm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic [REG_BITS-1:0]  wval;
  logic [REG_BITS-1:0]  rval;

  assign idx    = paddr[ADDR_W-1:2];
  assign wval   = pwdata[REG_BITS-1:0];
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_CENTER: cfg_nxt.center_level    = wval;
        REG_SPIKE:  cfg_nxt.spike_limit     = wval;
        REG_THR1:   cfg_nxt.threshold_one   = wval;
        REG_THR2:   cfg_nxt.threshold_two   = wval;
        REG_THR3:   cfg_nxt.threshold_three = wval;
        REG_THRF:   cfg_nxt.threshold_full  = wval;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER: rval = cfg_r.center_level;
      REG_SPIKE:  rval = cfg_r.spike_limit;
      REG_THR1:   rval = cfg_r.threshold_one;
      REG_THR2:   rval = cfg_r.threshold_two;
      REG_THR3:   rval = cfg_r.threshold_three;
      REG_THRF:   rval = cfg_r.threshold_full;
      default:    rval = '0;
    endcase
  end

  assign prdata = DATA_W'(rval);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_level    <= RST_CENTER;
      cfg_r.spike_limit     <= RST_SPIKE;
      cfg_r.threshold_one   <= RST_THR1;
      cfg_r.threshold_two   <= RST_THR2;
      cfg_r.threshold_three <= RST_THR3;
      cfg_r.threshold_full  <= RST_THRF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/pwlm_dp.sv */
// ============================================================================
// pwlm_dp: datapath of the level meter
// Middle average, deviation, level window memory, peak scan, bar pattern
// and result register.
// ============================================================================
module pwlm_dp import pwlm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  input  ctl_cmd_t  cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  logic [SAMPLE_BITS-1:0] smp_r [NUM_SAMPLES];
  logic                   cmd_r;
  logic [SAMPLE_BITS-1:0] min_r, max_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic [LEVEL_BITS-1:0]  level_r;
  logic [LEVEL_BITS-1:0]  peak_r;
  logic [LED_BITS-1:0]    bar_r;
  logic [WIN_AW-1:0]      wptr_r;
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W-1:0]      rd_cnt_r;
  logic                   rd_vld_r;
  logic [LEVEL_BITS-1:0]  rd_data_r;
  out_item_t              out_r;

  logic [LEVEL_BITS-1:0]  win_mem [WINDOW_DEPTH];

  logic [SAMPLE_BITS-1:0] mn, mx;
  logic [SUM_W-1:0]       sum;
  logic [MID_W-1:0]       mid;
  logic [PROD_W-1:0]      prod;
  logic [LEVEL_BITS-1:0]  avg_lvl;
  logic [LEVEL_BITS-1:0]  dev;
  logic [LEVEL_BITS-1:0]  lvl_new;
  logic [LED_BITS-1:0]    pat_new;

  // min, max and total of the set; the middle three sum to total-min-max
  always_comb begin
    mn  = smp_r[0];
    mx  = smp_r[0];
    sum = SUM_W'(smp_r[0]);
    for (int i = 1; i < NUM_SAMPLES; i++) begin
      if (smp_r[i] < mn) mn = smp_r[i];
      if (smp_r[i] > mx) mx = smp_r[i];
      sum = sum + SUM_W'(smp_r[i]);
    end
  end

  assign mid  = MID_W'(sum_r - SUM_W'(min_r) - SUM_W'(max_r));
  assign prod = PROD_W'(mid) * PROD_W'(DIV3_MUL);

  assign avg_lvl = LEVEL_BITS'(avg_r);
  assign dev     = (avg_lvl < cfg.center_level) ? (cfg.center_level - avg_lvl)
                                                : (avg_lvl - cfg.center_level);
  assign lvl_new = (dev > cfg.spike_limit) ? '0 : dev;

  // thresholds tested in order; no match keeps the pattern
  always_comb begin
    if (peak_r < cfg.threshold_one) begin
      pat_new = PAT_NONE;
    end else if (peak_r < cfg.threshold_two) begin
      pat_new = PAT_ONE;
    end else if (peak_r >= cfg.threshold_two && peak_r < cfg.threshold_three) begin
      pat_new = PAT_TWO;
    end else if (peak_r >= cfg.threshold_three && peak_r < cfg.threshold_full) begin
      pat_new = PAT_THREE;
    end else if (peak_r > cfg.threshold_full) begin
      pat_new = PAT_FULL;
    end else begin
      pat_new = bar_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r[0] <= in_data.sample_a;
      smp_r[1] <= in_data.sample_b;
      smp_r[2] <= in_data.sample_c;
      smp_r[3] <= in_data.sample_d;
      smp_r[4] <= in_data.sample_e;
      cmd_r    <= in_data.cmd;
    end
    if (cmd.sort_en) begin
      min_r <= mn;
      max_r <= mx;
      sum_r <= sum;
    end
    if (cmd.div_en) begin
      avg_r <= prod[DIV3_SHIFT +: SAMPLE_BITS];
    end
    if (cmd.load) begin
      level_r <= '0;
    end else if (cmd.push) begin
      level_r <= lvl_new;
    end
    if (cmd.load) begin
      peak_r <= '0;
    end else if (rd_vld_r && (rd_data_r > peak_r)) begin
      peak_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_r.level_pushed <= level_r;
      out_r.window_peak  <= peak_r;
      out_r.led_pattern  <= bar_r;
    end
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_mem[wptr_r] <= lvl_new;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= win_mem[rd_cnt_r[WIN_AW-1:0]];
    end
  end

  // control state; the fill count keeps unwritten entries out of the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      fill_r   <= '0;
      bar_r    <= PAT_NONE;
      rd_cnt_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.push) begin
        wptr_r <= (wptr_r == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
        if (fill_r != FILL_W'(WINDOW_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.load) begin
        rd_cnt_r <= '0;
      end else if (cmd.scan_rd) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (cmd.pat_en && (peak_r < cfg.spike_limit)) begin
        bar_r <= pat_new;
      end
    end
  end

  assign sts.cmd       = cmd_r;
  assign sts.scan_done = (rd_cnt_r == fill_r);
  assign out_data      = out_r;

endmodule

/* sv/pwlm_ctrl.sv */
// ============================================================================
// pwlm_ctrl: controller of the level meter
// Sequences one request through the datapath and owns the result valid.
// ============================================================================
module pwlm_ctrl import pwlm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SORT  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PUSH  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_PAT   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort_en = 1'b1;
        state_nxt   = (sts.cmd == CMD_REFRESH) ? ST_SCAN : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_PUSH;
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PAT;
      end
      ST_PAT: begin
        cmd.pat_en = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
